>>> sv/vn3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vn3_pkg: shared types and constants for the 3D value-noise pipeline
// Field widths, hash constants, pipeline depth and the stage enable bundle.
// ============================================================================
package vn3_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int WEIGHT_W    = 17;
    localparam int CELL_W      = 24;
    localparam int HASH_W      = 12;
    localparam int NOISE_W     = 16;
    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 8;

    localparam int FRONT_STAGES = 8;
    localparam int LERP_STAGES  = 6;
    localparam int NUM_STAGES   = FRONT_STAGES + LERP_STAGES;

    // Lattice primes and the hash modulus.
    localparam logic [6:0]  PRIME_X  = 7'd19;
    localparam logic [6:0]  PRIME_Y  = 7'd47;
    localparam logic [6:0]  PRIME_Z  = 7'd101;
    localparam logic [12:0] HASH_MOD = 13'd4093;

    // 2^24 mod 4093, used to make the residue of a negative cell Euclidean.
    localparam logic [12:0] CELL_WRAP = 13'd9;

    // m*65536/4093 = 16*m + (48*m + 2046)/4093; the second quotient comes from
    // a multiply by ceil(2^30/4093), exact over the whole range of m.
    localparam logic [5:0]  HASH_SCALE  = 6'd48;
    localparam logic [10:0] HASH_ROUND  = 11'd2046;
    localparam logic [18:0] HASH_RECIP  = 19'd262337;
    localparam int          RECIP_SHIFT = 30;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [HASH_W-1:0]         hash_t;
    typedef logic [WEIGHT_W-1:0]       weight_t;
    typedef logic signed [NOISE_W-1:0] sample_t;
    typedef logic [NUM_CORNERS-1:0][NOISE_W-1:0] corner_vec_t;

    typedef struct packed {
        logic [LERP_STAGES-1:0]  back_en;
        logic [FRONT_STAGES-1:0] front_en;
    } stage_en_t;

endpackage
`default_nettype wire

>>> sv/vn3_pipe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vn3_pipe_ctrl: valid bits and load enables of the noise pipeline
// One valid bit per stage; a stage loads when it is empty or its successor
// loads, so bubbles are squeezed out and a stall drops nothing.
// ============================================================================
module vn3_pipe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_ready,
    output logic               noise_valid,
    input  logic               noise_ready,
    output vn3_pkg::stage_en_t stage_en
);
    import vn3_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] en;

    // A stage may load if the output side is ready or some stage at or after
    // it is empty.
    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            en[k] = noise_ready ||
                    ((valid_reg | NUM_STAGES'((64'd1 << k) - 64'd1)) != '1);
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? point_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign point_ready       = en[0];
    assign noise_valid       = valid_reg[NUM_STAGES-1];
    assign stage_en.front_en = en[FRONT_STAGES-1:0];
    assign stage_en.back_en  = en[NUM_STAGES-1:FRONT_STAGES];

    logic in_acc;
    logic out_acc;
    assign in_acc  = point_valid && point_ready;
    assign out_acc = noise_valid && noise_ready;

    // Words in flight change only by what enters and what leaves.
    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(valid_reg) ==
            $countones($past(valid_reg)) + $past(in_acc) - $past(out_acc)))
        else $error("pipeline word count does not match handshakes");

    // An accepted word lands in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(in_acc) |-> valid_reg[0])
        else $error("accepted word missing from first stage");

    // A full first stage that cannot move keeps its word.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !en[0] |=> valid_reg[0])
        else $error("stalled first stage lost its word");

endmodule
`default_nettype wire

>>> sv/vn3_fade.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vn3_fade: quintic fade weight of one coordinate
// Takes the Q0.16 fraction to 6t^5-15t^4+10t^3 in four stages, then delays
// the weight so it lines up with the corner values.
// ============================================================================
module vn3_fade #(
    parameter int FRACTION_BITS = vn3_pkg::FRACTION_BITS_DEF
) (
    input  logic               clk,
    input  vn3_pkg::stage_en_t stage_en,
    input  vn3_pkg::coord_t    coord,
    output vn3_pkg::weight_t   weight
);
    import vn3_pkg::*;

    localparam int DELAY_STAGES = FRONT_STAGES - 4;

    logic [FRAC_W-1:0] frac_q16;

    generate
        if (FRACTION_BITS >= FRAC_W)
        begin : g_trunc
            assign frac_q16 = coord[FRACTION_BITS-1 -: FRAC_W];
        end
        else
        begin : g_widen
            assign frac_q16 = {coord[FRACTION_BITS-1:0], {(FRAC_W-FRACTION_BITS){1'b0}}};
        end
    endgenerate

    // Stage 1: t and t^2.
    logic [FRAC_W-1:0] t_reg;
    logic [31:0]       t2_reg, t2_next;
    assign t2_next = 32'(frac_q16) * 32'(frac_q16);

    // Stage 2: t^3 and g = 6t^2 - 15*2^16*t + 10*2^32, which stays positive.
    logic [47:0] t3_reg, t3_next;
    logic [35:0] g_reg, g_next;
    logic [36:0] g_full;
    assign t3_next = 48'(t2_reg) * 48'(t_reg);
    assign g_full  = 37'(t2_reg) * 37'd6 + (37'd10 << 32) - 37'({t_reg, 16'b0}) * 37'd15;
    assign g_next  = g_full[35:0];

    // Stage 3: t^3 * g as four partial products.
    logic [41:0] pp_reg  [4];
    logic [41:0] pp_next [4];
    assign pp_next[0] = 42'(t3_reg[47:24]) * 42'(g_reg[35:18]);
    assign pp_next[1] = 42'(t3_reg[47:24]) * 42'(g_reg[17:0]);
    assign pp_next[2] = 42'(t3_reg[23:0])  * 42'(g_reg[35:18]);
    assign pp_next[3] = 42'(t3_reg[23:0])  * 42'(g_reg[17:0]);

    // Stage 4: sum, round half up at 2^64.
    logic [84:0] prod_sum;
    weight_t     w_reg, w_next;
    assign prod_sum = (85'(pp_reg[0]) << 42) + (85'(pp_reg[1]) << 24)
                    + (85'(pp_reg[2]) << 18) + 85'(pp_reg[3]) + (85'd1 << 63);
    assign w_next   = prod_sum[80:64];

    weight_t w_dly_reg [DELAY_STAGES];

    always_ff @(posedge clk)
    begin
        if (stage_en.front_en[0])
        begin
            t_reg  <= frac_q16;
            t2_reg <= t2_next;
        end
        if (stage_en.front_en[1])
        begin
            t3_reg <= t3_next;
            g_reg  <= g_next;
        end
        if (stage_en.front_en[2])
        begin
            for (int i = 0; i < 4; i++)
            begin
                pp_reg[i] <= pp_next[i];
            end
        end
        if (stage_en.front_en[3])
        begin
            w_reg <= w_next;
        end
        if (stage_en.front_en[4])
        begin
            w_dly_reg[0] <= w_reg;
        end
        for (int i = 1; i < DELAY_STAGES; i++)
        begin
            if (stage_en.front_en[4+i])
            begin
                w_dly_reg[i] <= w_dly_reg[i-1];
            end
        end
    end

    assign weight = w_dly_reg[DELAY_STAGES-1];

endmodule
`default_nettype wire

>>> sv/vn3_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vn3_hash: lattice cell and Blum-Blum-Shub corner values
// Reduces each cell index mod 4093, forms the eight corner seeds, squares
// twice mod 4093 and scales to Q1.15, over eight stages.
// ============================================================================
module vn3_hash #(
    parameter int FRACTION_BITS = vn3_pkg::FRACTION_BITS_DEF
) (
    input  logic                 clk,
    input  vn3_pkg::stage_en_t   stage_en,
    input  vn3_pkg::coord_t      coord_x,
    input  vn3_pkg::coord_t      coord_y,
    input  vn3_pkg::coord_t      coord_z,
    output vn3_pkg::corner_vec_t corners
);
    import vn3_pkg::*;

    // One subtraction of the modulus; valid for inputs below twice of it.
    function automatic hash_t cond_sub(input logic [12:0] v);
        logic [12:0] d;
        d = v - HASH_MOD;
        return (v >= HASH_MOD) ? d[11:0] : v[11:0];
    endfunction

    // 24-bit value mod 4093 by folding on 4096 = 3 (mod 4093).
    function automatic hash_t mod_24(input logic [23:0] v);
        logic [13:0] f1;
        logic [12:0] f2;
        f1 = 14'(v[23:12]) * 14'd3 + 14'(v[11:0]);
        f2 = 13'(f1[13:12]) * 13'd3 + 13'(f1[11:0]);
        return cond_sub(f2);
    endfunction

    coord_t coord_arr [NUM_AXES];
    assign coord_arr[0] = coord_x;
    assign coord_arr[1] = coord_y;
    assign coord_arr[2] = coord_z;

    logic [13:0] fold_reg [NUM_AXES];
    logic [13:0] fold_next [NUM_AXES];
    logic        sign_reg [NUM_AXES];
    logic        sign_next [NUM_AXES];
    hash_t       cell_reg [NUM_AXES];
    hash_t       cell_next [NUM_AXES];

    genvar a;
    generate
        for (a = 0; a < NUM_AXES; a++)
        begin : g_axis
            logic signed [COORD_W-1:0] shifted;
            logic [CELL_W-1:0]         cell_bits;
            logic [12:0]               fold2;
            hash_t                     resid;
            logic [12:0]               wrap_add;
            logic [12:0]               wrap_sub;

            // Stage 1: floor of the coordinate, first fold of its residue.
            assign shifted      = coord_arr[a] >>> FRACTION_BITS;
            assign cell_bits    = shifted[CELL_W-1:0];
            assign fold_next[a] = 14'(cell_bits[23:12]) * 14'd3 + 14'(cell_bits[11:0]);
            assign sign_next[a] = cell_bits[CELL_W-1];

            // Stage 2: finish the residue, then correct for a negative cell.
            assign fold2    = 13'(fold_reg[a][13:12]) * 13'd3 + 13'(fold_reg[a][11:0]);
            assign resid    = cond_sub(fold2);
            assign wrap_add = 13'(resid) + HASH_MOD - CELL_WRAP;
            assign wrap_sub = 13'(resid) - CELL_WRAP;
            always_comb
            begin
                if (!sign_reg[a])
                begin
                    cell_next[a] = resid;
                end
                else if (13'(resid) < CELL_WRAP)
                begin
                    cell_next[a] = wrap_add[11:0];
                end
                else
                begin
                    cell_next[a] = wrap_sub[11:0];
                end
            end
        end
    endgenerate

    // Stage 3: base seed from the reduced cells.
    logic [19:0] base_reg, base_next;
    assign base_next = 20'(cell_reg[0]) * 20'(PRIME_X) + 20'(cell_reg[1]) * 20'(PRIME_Y)
                     + 20'(cell_reg[2]) * 20'(PRIME_Z);

    // Stage 4: base mod 4093, then the corner seeds.
    logic [12:0] base_fold;
    hash_t       base_mod;
    assign base_fold = 13'(base_reg[19:12]) * 13'd3 + 13'(base_reg[11:0]);
    assign base_mod  = cond_sub(base_fold);

    hash_t       seed_reg [NUM_CORNERS];
    hash_t       seed_next [NUM_CORNERS];
    logic [23:0] sq1_reg [NUM_CORNERS];
    logic [23:0] sq1_next [NUM_CORNERS];
    logic [23:0] sq2_reg [NUM_CORNERS];
    logic [23:0] sq2_next [NUM_CORNERS];
    hash_t       m_reg [NUM_CORNERS];
    hash_t       m_next [NUM_CORNERS];
    logic [36:0] q_reg [NUM_CORNERS];
    logic [36:0] q_next [NUM_CORNERS];
    logic [NOISE_W-1:0] corner_reg [NUM_CORNERS];
    logic [NOISE_W-1:0] corner_next [NUM_CORNERS];

    genvar k;
    generate
        for (k = 0; k < NUM_CORNERS; k++)
        begin : g_corner
            localparam logic [7:0] CORNER_OFF = 8'((k % 2) * int'(PRIME_X)
                + ((k / 2) % 2) * int'(PRIME_Y) + ((k / 4) % 2) * int'(PRIME_Z));
            hash_t       r1;
            logic [17:0] scaled;
            logic [6:0]  q_hi;
            logic [15:0] unsigned_val;

            assign seed_next[k] = cond_sub(13'(base_mod) + 13'(CORNER_OFF));

            // Stage 5: first square.
            assign sq1_next[k] = 24'(seed_reg[k]) * 24'(seed_reg[k]);

            // Stage 6: reduce, second square.
            assign r1          = mod_24(sq1_reg[k]);
            assign sq2_next[k] = 24'(r1) * 24'(r1);

            // Stage 7: reduce, start the scale to 16 bits.
            assign m_next[k] = mod_24(sq2_reg[k]);
            assign scaled    = 18'(m_next[k]) * 18'(HASH_SCALE) + 18'(HASH_ROUND);
            assign q_next[k] = 37'(scaled) * 37'(HASH_RECIP);

            // Stage 8: 16*m plus the small quotient, recentred on zero.
            assign q_hi           = q_reg[k][36:RECIP_SHIFT];
            assign unsigned_val   = {m_reg[k], 4'b0} + 16'(q_hi);
            assign corner_next[k] = {~unsigned_val[15], unsigned_val[14:0]};

            assign corners[k] = corner_reg[k];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (stage_en.front_en[0])
            begin
                fold_reg[i] <= fold_next[i];
                sign_reg[i] <= sign_next[i];
            end
            if (stage_en.front_en[1])
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
        if (stage_en.front_en[2])
        begin
            base_reg <= base_next;
        end
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            if (stage_en.front_en[3])
            begin
                seed_reg[i] <= seed_next[i];
            end
            if (stage_en.front_en[4])
            begin
                sq1_reg[i] <= sq1_next[i];
            end
            if (stage_en.front_en[5])
            begin
                sq2_reg[i] <= sq2_next[i];
            end
            if (stage_en.front_en[6])
            begin
                m_reg[i] <= m_next[i];
                q_reg[i] <= q_next[i];
            end
            if (stage_en.front_en[7])
            begin
                corner_reg[i] <= corner_next[i];
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/vn3_lerp.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vn3_lerp: trilinear interpolation of the corner values
// Three lerp levels (x, y, z), each a multiply stage and an add stage.
// ============================================================================
module vn3_lerp (
    input  logic                 clk,
    input  vn3_pkg::stage_en_t   stage_en,
    input  vn3_pkg::corner_vec_t corners,
    input  vn3_pkg::weight_t     weight_x,
    input  vn3_pkg::weight_t     weight_y,
    input  vn3_pkg::weight_t     weight_z,
    output vn3_pkg::sample_t     noise_value
);
    import vn3_pkg::*;

    function automatic logic signed [34:0] lerp_mul(input sample_t lo, input sample_t hi,
                                                    input weight_t w);
        logic signed [16:0] d;
        logic signed [17:0] ws;
        logic signed [34:0] p;
        d  = $signed({hi[15], hi}) - $signed({lo[15], lo});
        ws = $signed({1'b0, w});
        p  = d * ws;
        return p;
    endfunction

    // lo + floor((p + 2^15) / 2^16); the result lies between the two ends.
    function automatic sample_t lerp_add(input sample_t lo, input logic signed [34:0] p);
        logic signed [34:0] s;
        s = (p + 35'sd32768) >>> 16;
        return lo + $signed(s[15:0]);
    endfunction

    // X level.
    logic signed [34:0] p1_reg [4];
    sample_t            a1_reg [4];
    sample_t            x_reg [4];
    sample_t            x_next [4];
    weight_t            wy1_reg, wy2_reg;
    weight_t            wz1_reg, wz2_reg, wz3_reg, wz4_reg;

    // Y level.
    logic signed [34:0] p2_reg [2];
    sample_t            a2_reg [2];
    sample_t            y_reg [2];
    sample_t            y_next [2];

    // Z level.
    logic signed [34:0] p3_reg;
    sample_t            a3_reg;
    sample_t            out_reg, out_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            x_next[i] = lerp_add(a1_reg[i], p1_reg[i]);
        end
        for (int i = 0; i < 2; i++)
        begin
            y_next[i] = lerp_add(a2_reg[i], p2_reg[i]);
        end
        out_next = lerp_add(a3_reg, p3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.back_en[0])
        begin
            for (int i = 0; i < 4; i++)
            begin
                p1_reg[i] <= lerp_mul($signed(corners[2*i]), $signed(corners[2*i+1]), weight_x);
                a1_reg[i] <= $signed(corners[2*i]);
            end
            wy1_reg <= weight_y;
            wz1_reg <= weight_z;
        end
        if (stage_en.back_en[1])
        begin
            for (int i = 0; i < 4; i++)
            begin
                x_reg[i] <= x_next[i];
            end
            wy2_reg <= wy1_reg;
            wz2_reg <= wz1_reg;
        end
        if (stage_en.back_en[2])
        begin
            for (int i = 0; i < 2; i++)
            begin
                p2_reg[i] <= lerp_mul(x_reg[2*i], x_reg[2*i+1], wy2_reg);
                a2_reg[i] <= x_reg[2*i];
            end
            wz3_reg <= wz2_reg;
        end
        if (stage_en.back_en[3])
        begin
            for (int i = 0; i < 2; i++)
            begin
                y_reg[i] <= y_next[i];
            end
            wz4_reg <= wz3_reg;
        end
        if (stage_en.back_en[4])
        begin
            p3_reg <= lerp_mul(y_reg[0], y_reg[1], wz4_reg);
            a3_reg <= y_reg[0];
        end
        if (stage_en.back_en[5])
        begin
            out_reg <= out_next;
        end
    end

    assign noise_value = out_reg;

endmodule
`default_nettype wire

>>> sv/value_noise_3d_bbs.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// value_noise_3d_bbs: 3D lattice value noise, BBS corner hash, quintic fade
// Maps a signed fixed-point point to a Q1.15 noise sample in a 14-stage
// pipeline.
// ============================================================================
//
//  Channel  | Handshake                  | Word
//  ---------+----------------------------+--------------------------------
//  point    | point_valid / point_ready  | point_x, point_y, point_z (s32)
//  noise    | noise_valid / noise_ready  | noise_value (s16, Q1.15)
//
//  Throughput is one word per cycle unless the output stalls; the accepting
//  edge loads the first of 14 register stages, and noise_valid rises when
//  that word reaches the last one.  The depth is set by the fade's wide
//  product, which is split into partial products, and the two chained
//  squares mod 4093 of the corner hash, followed by three multiply-and-add
//  lerp levels.  Reset clears only the per-stage valid bits; data registers
//  are not reset.  A stall at the output holds the full stages in place
//  while empty stages ahead of them keep filling, so point_ready stays high
//  until every stage holds a word.
//
module value_noise_3d_bbs #(
    parameter int FRACTION_BITS = vn3_pkg::FRACTION_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_ready,
    input  vn3_pkg::coord_t  point_x,
    input  vn3_pkg::coord_t  point_y,
    input  vn3_pkg::coord_t  point_z,
    output logic             noise_valid,
    input  logic             noise_ready,
    output vn3_pkg::sample_t noise_value
);
    import vn3_pkg::*;

    stage_en_t   stage_en;
    weight_t     weight_x;
    weight_t     weight_y;
    weight_t     weight_z;
    corner_vec_t corners;

    // Valid bits and per-stage load enables for every datapath part below.
    vn3_pipe_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .noise_valid (noise_valid),
        .noise_ready (noise_ready),
        .stage_en    (stage_en)
    );

    // One fade unit per axis; each weight leaves aligned with the corners.
    vn3_fade #(.FRACTION_BITS(FRACTION_BITS)) u_fade_x (
        .clk      (clk),
        .stage_en (stage_en),
        .coord    (point_x),
        .weight   (weight_x)
    );

    vn3_fade #(.FRACTION_BITS(FRACTION_BITS)) u_fade_y (
        .clk      (clk),
        .stage_en (stage_en),
        .coord    (point_y),
        .weight   (weight_y)
    );

    vn3_fade #(.FRACTION_BITS(FRACTION_BITS)) u_fade_z (
        .clk      (clk),
        .stage_en (stage_en),
        .coord    (point_z),
        .weight   (weight_z)
    );

    // Cell indices and the eight hashed corner values, in the same eight
    // stages as the fade.
    vn3_hash #(.FRACTION_BITS(FRACTION_BITS)) u_hash (
        .clk      (clk),
        .stage_en (stage_en),
        .coord_x  (point_x),
        .coord_y  (point_y),
        .coord_z  (point_z),
        .corners  (corners)
    );

    // Trilinear blend; its last register is the output register.
    vn3_lerp u_lerp (
        .clk         (clk),
        .stage_en    (stage_en),
        .corners     (corners),
        .weight_x    (weight_x),
        .weight_y    (weight_y),
        .weight_z    (weight_z),
        .noise_value (noise_value)
    );

endmodule
`default_nettype wire

>>> dv/value_noise_3d_bbs_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// value_noise_3d_bbs_tb: self-checking bench for the 3D value-noise pipeline
// Sends directed and random points through the valid/ready point channel,
// predicts every noise sample with a behavioral model of the lattice hash,
// quintic fade and trilinear blend, and checks each output word in order.
// ============================================================================
module value_noise_3d_bbs_tb;

    import vn3_pkg::coord_t;
    import vn3_pkg::sample_t;
    import vn3_pkg::weight_t;

    localparam int FRAC_BITS = vn3_pkg::FRACTION_BITS_DEF;

    // The fraction is brought to Q0.16 before the fade: shifted up when the
    // format has fewer fraction bits, truncated when it has more.
    localparam int FRAC_UP   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int FRAC_DOWN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;

    // Lattice primes along each axis and the hash modulus. They are kept as
    // signed 64-bit values so that seed arithmetic never turns unsigned.
    localparam longint STEP_X      = 19;
    localparam longint STEP_Y      = 47;
    localparam longint STEP_Z      = 101;
    localparam longint LATTICE_MOD = 4093;

    // Number of register stages in the pipeline, used for the settling time
    // at the end of the run.
    localparam int PIPE_DEPTH = 14;

    localparam int RANDOM_POINTS = 800;
    localparam int FILL_POINTS   = 40;
    localparam int SINK_HOLD_CYC = 80;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // One expected noise word together with the point that produced it, so
    // that a mismatch can be traced back to its input.
    typedef struct {
        coord_t  x;
        coord_t  y;
        coord_t  z;
        sample_t noise;
    } sample_check_t;

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    point_valid = 1'b0;
    logic    point_ready;
    coord_t  point_x     = '0;
    coord_t  point_y     = '0;
    coord_t  point_z     = '0;
    logic    noise_valid;
    logic    noise_ready = 1'b0;
    sample_t noise_value;

    point_t        points_to_send[$];
    sample_check_t pending_samples[$];

    int  error_count = 0;
    int  send_gap    = 0;
    int  sink_stall  = 0;
    // Set by the stimulus process: sink_hold parks the receiver for a long
    // stretch, no_gaps turns off idling on both sides for a burst.
    bit  sink_hold   = 1'b0;
    bit  no_gaps     = 1'b0;

    value_noise_3d_bbs #(
        .FRACTION_BITS (FRAC_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .noise_valid (noise_valid),
        .noise_ready (noise_ready),
        .noise_value (noise_value)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Noise predictor
    // ------------------------------------------------------------------------

    // Integer cell of a coordinate: an arithmetic shift floors, so negative
    // points land in the cell below with a non-negative fraction.
    function automatic longint cell_of(coord_t raw);
        longint v;
        v = raw;
        return v >>> FRAC_BITS;
    endfunction

    // Quintic fade 6t^5 - 15t^4 + 10t^3 on a Q0.16 fraction, rounded half up
    // to Q1.16. The product fits in 80 bits, so it is formed at 128.
    function automatic weight_t quintic_weight(bit [127:0] t);
        bit [127:0] t2;
        bit [127:0] g;
        bit [127:0] t3;
        bit [127:0] prod;
        t2   = t * t;
        g    = 6 * t2 + (128'd10 << 32) - 15 * (t << 16);
        t3   = t2 * t;
        prod = t3 * g + (128'd1 << 63);
        return prod[80:64];
    endfunction

    function automatic weight_t weight_of(coord_t raw);
        bit [63:0] f;
        f = {32'd0, raw} & ((64'd1 << FRAC_BITS) - 1);
        return quintic_weight((f << FRAC_UP) >> FRAC_DOWN);
    endfunction

    // Corner value of a lattice seed: Euclidean residue, squared twice mod
    // the modulus, then scaled to Q1.15 with rounding to nearest.
    function automatic longint lattice_value(longint seed);
        longint m;
        m = seed % LATTICE_MOD;
        if (m < 0)
            m += LATTICE_MOD;
        m = (m * m) % LATTICE_MOD;
        m = (m * m) % LATTICE_MOD;
        return (m * 65536 + LATTICE_MOD / 2) / LATTICE_MOD - 32768;
    endfunction

    // Linear blend with a Q1.16 weight; the rounded step is floored, so the
    // result never leaves the interval between the two ends.
    function automatic longint blend(longint from_val, longint to_val, weight_t w);
        longint p;
        p = (to_val - from_val) * longint'(w) + 32768;
        return from_val + (p >>> 16);
    endfunction

    function automatic sample_t noise_at(coord_t x, coord_t y, coord_t z);
        longint  base;
        longint  seed;
        longint  corner[8];
        longint  i0;
        longint  i1;
        longint  j0;
        longint  j1;
        longint  a;
        longint  b;
        weight_t wx;
        weight_t wy;
        weight_t wz;
        int      k;
        base = STEP_X * cell_of(x) + STEP_Y * cell_of(y) + STEP_Z * cell_of(z);
        for (k = 0; k < 8; k++)
        begin
            seed = base;
            if (k[0])
                seed += STEP_X;
            if (k[1])
                seed += STEP_Y;
            if (k[2])
                seed += STEP_Z;
            corner[k] = lattice_value(seed);
        end
        wx = weight_of(x);
        wy = weight_of(y);
        wz = weight_of(z);
        // Blend along x between the four corner pairs, then along y, then along z.
        i0 = blend(corner[0], corner[1], wx);
        i1 = blend(corner[2], corner[3], wx);
        j0 = blend(corner[4], corner[5], wx);
        j1 = blend(corner[6], corner[7], wx);
        a  = blend(i0, i1, wy);
        b  = blend(j0, j1, wy);
        return sample_t'(blend(a, b, wz));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none, sometimes a few cycles, now and then a long
    // gap. During a burst no idling happens at all.
    function automatic int idle_cycles();
        int unsigned roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Random coordinate. Some are raw 32-bit words so that every bit toggles
    // and the far ends of the range show up; the rest sit in small cells on
    // both sides of zero, with fractions that are random or on the edges of
    // the fade (zero, one LSB, one half, all ones).
    function automatic coord_t random_coord();
        int unsigned pick;
        logic [15:0] cell_idx;
        logic [15:0] frac;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return coord_t'($urandom);
        cell_idx = 16'($urandom_range(0, 255)) - 16'd128;
        if (pick < 8)
            frac = 16'($urandom);
        else
            case ($urandom_range(0, 3))
                0:       frac = 16'h0000;
                1:       frac = 16'h0001;
                2:       frac = 16'h8000;
                default: frac = 16'hFFFF;
            endcase
        return {cell_idx, frac};
    endfunction

    task automatic queue_point(coord_t x, coord_t y, coord_t z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        points_to_send.push_back(p);
    endtask

    task automatic queue_random_points(int count);
        int n;
        for (n = 0; n < count; n++)
            queue_point(random_coord(), random_coord(), random_coord());
    endtask

    // Waits, on falling edges so that the driver and the monitor have settled,
    // until no point is queued or offered and no noise word is outstanding.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (points_to_send.size() != 0 || point_valid || pending_samples.size() != 0);
    endtask

    task automatic flag_mismatch(string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Point driver
    // ------------------------------------------------------------------------
    // A new word is taken from the queue only when the channel is free, i.e.
    // nothing is offered or the offered word is being accepted at this edge,
    // so a word that is waiting keeps valid high and its payload steady. The
    // expected noise of each accepted word is computed at the accepting edge.
    always @(posedge clk or negedge rst_n)
    begin : point_driver
        point_t        nxt;
        sample_check_t want;
        if (!rst_n)
        begin
            point_valid <= 1'b0;
            point_x     <= '0;
            point_y     <= '0;
            point_z     <= '0;
            send_gap    <= 0;
        end
        else
        begin
            if (point_valid && point_ready)
            begin
                want.x     = point_x;
                want.y     = point_y;
                want.z     = point_z;
                want.noise = noise_at(point_x, point_y, point_z);
                pending_samples.push_back(want);
            end
            if (!point_valid || point_ready)
            begin
                if (send_gap != 0)
                begin
                    point_valid <= 1'b0;
                    send_gap    <= send_gap - 1;
                end
                else if (points_to_send.size() != 0)
                begin
                    nxt = points_to_send.pop_front();
                    point_x     <= nxt.x;
                    point_y     <= nxt.y;
                    point_z     <= nxt.z;
                    point_valid <= 1'b1;
                    send_gap    <= idle_cycles();
                end
                else
                begin
                    point_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Noise monitor and receiver
    // ------------------------------------------------------------------------
    // Every accepted noise word is compared with the oldest expectation. The
    // ready side idles at random on its own schedule, independent of whether
    // a word is on offer, and is parked low while sink_hold is set.
    always @(posedge clk or negedge rst_n)
    begin : noise_monitor
        sample_check_t want;
        int            stall;
        if (!rst_n)
        begin
            noise_ready <= 1'b0;
            sink_stall  <= 0;
        end
        else
        begin
            if (noise_valid && noise_ready)
            begin
                if (pending_samples.size() == 0)
                begin
                    flag_mismatch($sformatf("noise word %0d with no point outstanding",
                                            noise_value));
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (noise_value !== want.noise)
                        flag_mismatch($sformatf(
                            "point (%h, %h, %h): noise_value %0d, expected %0d",
                            want.x, want.y, want.z, noise_value, want.noise));
                end
            end
            if (sink_hold)
            begin
                noise_ready <= 1'b0;
            end
            else if (sink_stall != 0)
            begin
                noise_ready <= 1'b0;
                sink_stall  <= sink_stall - 1;
            end
            else
            begin
                stall = idle_cycles();
                noise_ready <= (stall == 0);
                if (stall != 0)
                    sink_stall <= stall - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed points. The origin gives a zero seed, whose corner value
        // is the most negative one. Integer points have a zero fade weight,
        // so the sample equals a corner value exactly.
        queue_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_point(32'h0003_0000, 32'hFFFB_0000, 32'h0011_0000);
        // A point just below zero lies in cell -1 with fraction 0.75.
        queue_point(32'hFFFF_C000, 32'hFFFF_C000, 32'hFFFF_C000);
        queue_point(32'hFFFF_C000, 32'h0000_C000, 32'h0000_0000);
        queue_point(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        // Extremes of the coordinate range give the largest seeds of either
        // sign; the seed arithmetic must not wrap.
        queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_point(32'h7FFF_0000, 32'h8001_0000, 32'h7FFF_0000);
        // Edges of the fade: one LSB, one half and the largest fraction.
        queue_point(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        queue_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        queue_point(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        queue_point(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_8000);
        // Negative seeds that need the Euclidean residue.
        queue_point(32'hFC18_0000, 32'h0003_4000, 32'hFFF8_8000);
        queue_point(32'hFFF0_1234, 32'hFFE0_ABCD, 32'hFFC0_7777);
        // Alternating bit patterns on every field.
        queue_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333);
        queue_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC);
        wait_drained();

        // Back-pressure: the receiver is parked while the sender keeps
        // offering words, so the pipeline fills and point_ready must drop.
        // No idling on either side for this stretch.
        no_gaps   <= 1'b1;
        sink_hold <= 1'b1;
        queue_random_points(FILL_POINTS);
        repeat (SINK_HOLD_CYC) @(negedge clk);
        sink_hold <= 1'b0;
        queue_random_points(110);
        while (points_to_send.size() != 0)
            @(negedge clk);
        no_gaps <= 1'b0;

        // Random traffic with idling on both sides. Halfway through the
        // sender stops until every outstanding noise word has come back.
        queue_random_points(RANDOM_POINTS / 2 - 110);
        wait_drained();
        queue_random_points(RANDOM_POINTS / 2);
        wait_drained();

        // Let the pipeline settle so that any stray word would be caught.
        repeat (PIPE_DEPTH + 16) @(negedge clk);

        if (error_count == 0)
            $display("value_noise_3d_bbs_tb: clean");
        else
            $display("value_noise_3d_bbs_tb: errors");
        $finish;
    end

    // Run limit, several times the slowest correct run with the longest gaps
    // and stalls on every word.
    initial
    begin
        #4000000;
        $display("value_noise_3d_bbs_tb: errors");
        $finish;
    end

endmodule
